// File: rtl/olia_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olia_pkg
// Shared types and constants of the ordered list insert block.
// ----------------------------------------------------------------------------
package olia_pkg;

  localparam int DepthDefault = 32;
  localparam int CmdW         = 2;
  localparam int PosW         = 7;
  localparam int ValW         = 32;
  localparam int StatW        = 3;

  typedef enum logic [CmdW-1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_READ   = 2'd2
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_STORED = 3'd0,
    ST_BEYOND = 3'd1,
    ST_FULL   = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_READ   = 3'd4
  } stat_e;

  typedef enum logic [2:0] {
    SEL_HOLD = 3'd0,
    SEL_NEW  = 3'd1,
    SEL_PREV = 3'd2,
    SEL_NEXT = 3'd3,
    SEL_HEAD = 3'd4
  } sel_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_e;

  typedef struct packed {
    logic [CmdW-1:0] command;
    logic [PosW-1:0] position;
    logic [ValW-1:0] value;
  } in_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [ValW-1:0]  element;
    logic             last;
  } out_t;

  typedef struct packed {
    sel_e            sel;
    logic [ValW-1:0] value;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/olia_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olia_cell
// One list slot: holds, loads a new value, or takes a neighbor's or the head slot's value.
// ----------------------------------------------------------------------------
module olia_cell import olia_pkg::*; (
  input  wire logic             clk_i,
  input  wire cell_ctrl_t       ctrl_i,
  input  wire logic [ValW-1:0]  prev_i,
  input  wire logic [ValW-1:0]  next_i,
  input  wire logic [ValW-1:0]  head_i,
  output logic      [ValW-1:0]  data_o
);

  logic [ValW-1:0] data_q, data_d;

  always_comb begin
    unique case (ctrl_i.sel)
      SEL_NEW:  data_d = ctrl_i.value;
      SEL_PREV: data_d = prev_i;
      SEL_NEXT: data_d = next_i;
      SEL_HEAD: data_d = head_i;
      default:  data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

// File: rtl/ordered_list_insert_at_position.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_insert_at_position
// Ordered list of up to DEPTH values kept in a row of slot cells.
// ----------------------------------------------------------------------------
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   in_data_i  (in_t)
// out      output     out_valid_o / out_stall_i out_data_o (out_t)
//
// append writes the next free slot; insert writes its slot and all later slots shift up together
// read first enters the read state, then gives one element per cycle while the output is not
// stalled, as the row rotates once through the list
// one item at a time; the next transfer waits for the read to finish
// reset clears the count; slot contents are not reset
// a stalled result holds the output register and blocks new input
// ----------------------------------------------------------------------------
module ordered_list_insert_at_position import olia_pkg::*; #(
  parameter int DEPTH = DepthDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  localparam int CntW = $clog2(DEPTH + 1);

  state_e          state_q, state_d;
  logic [CntW-1:0] used_q, used_d;
  logic [CntW-1:0] rd_cnt_q, rd_cnt_d;
  logic            out_valid_q, out_valid_d;
  out_t            out_q, out_d;

  logic [ValW-1:0] cell_data [DEPTH];
  cell_ctrl_t      cell_ctrl [DEPTH];

  logic            in_acc, out_free;
  logic [PosW-1:0] pos_eff, used_ext;
  logic            beyond, full, rd_last;
  logic            do_app, do_ins, do_rot;

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc = in_valid_i && !in_stall_o;

  assign pos_eff = (in_data_i.position == '0) ? PosW'(1) : in_data_i.position;
  assign used_ext = PosW'(used_q);
  assign beyond = pos_eff > used_ext;
  assign full = used_q == CntW'(DEPTH);
  assign rd_last = rd_cnt_q == (used_q - CntW'(1));

  assign do_app = in_acc && (in_data_i.command == CMD_APPEND) && !full;
  assign do_ins = in_acc && (in_data_i.command == CMD_INSERT) && !beyond && !full;
  assign do_rot = (state_q == S_READ) && out_free;

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    rd_cnt_d    = rd_cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (in_acc) begin
      out_d.element = '0;
      out_d.last    = 1'b1;
      unique case (in_data_i.command)
        CMD_APPEND: begin
          out_valid_d  = 1'b1;
          out_d.status = full ? ST_FULL : ST_STORED;
          if (!full) used_d = used_q + CntW'(1);
        end
        CMD_INSERT: begin
          out_valid_d = 1'b1;
          if (beyond) out_d.status = ST_BEYOND;
          else if (full) out_d.status = ST_FULL;
          else begin
            out_d.status = ST_STORED;
            used_d       = used_q + CntW'(1);
          end
        end
        CMD_READ: begin
          if (used_q == '0) begin
            out_valid_d  = 1'b1;
            out_d.status = ST_EMPTY;
          end else begin
            state_d  = S_READ;
            rd_cnt_d = '0;
          end
        end
        default: ;
      endcase
    end else if (do_rot) begin
      out_valid_d   = 1'b1;
      out_d.status  = ST_READ;
      out_d.element = cell_data[0];
      out_d.last    = rd_last;
      rd_cnt_d      = rd_cnt_q + CntW'(1);
      if (rd_last) state_d = S_IDLE;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [PosW-1:0] idx;
    logic [ValW-1:0] prev_w, next_w;

    assign idx = PosW'(i);

    if (i == 0) begin : g_first
      assign prev_w = cell_data[0];
    end else begin : g_mid
      assign prev_w = cell_data[i-1];
    end
    if (i < DEPTH - 1) begin : g_nxt
      assign next_w = cell_data[i+1];
    end else begin : g_end
      assign next_w = cell_data[0];
    end

    always_comb begin
      cell_ctrl[i].value = in_data_i.value;
      cell_ctrl[i].sel   = SEL_HOLD;
      if (do_app && (idx == used_ext)) begin
        cell_ctrl[i].sel = SEL_NEW;
      end else if (do_ins && (idx == pos_eff)) begin
        cell_ctrl[i].sel = SEL_NEW;
      end else if (do_ins && (idx > pos_eff) && (idx <= used_ext)) begin
        cell_ctrl[i].sel = SEL_PREV;
      end else if (do_rot && (idx == used_ext - PosW'(1))) begin
        cell_ctrl[i].sel = SEL_HEAD;
      end else if (do_rot && (idx < used_ext)) begin
        cell_ctrl[i].sel = SEL_NEXT;
      end
    end

    olia_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl[i]),
      .prev_i (prev_w),
      .next_i (next_w),
      .head_i (cell_data[0]),
      .data_o (cell_data[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      rd_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      rd_cnt_q    <= rd_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntW'(DEPTH))
    else $error("element count above depth");

  a_read_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> in_stall_o)
    else $error("input taken during read out");

  a_read_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |=> (used_q == $past(used_q)))
    else $error("element count changed during read out");

  a_last_ends_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == ST_READ && out_q.last) |-> (state_q == S_IDLE))
    else $error("read out still running after last element");

endmodule
`default_nettype wire
